// ===== rtl/core/sfc_pkg.sv =====
package sfc_pkg;

   typedef enum logic [2:0] {
      FMT_U8       = 3'd0,
      FMT_S16      = 3'd1,
      FMT_S32      = 3'd2,
      FMT_F32      = 3'd3,
      FMT_F64      = 3'd4,
      FMT_S8_DELTA = 3'd5,
      FMT_S16_DELTA= 3'd6
   } sample_format_type;

   localparam logic [31:0] SIGN32 = 32'h8000_0000;
   localparam logic [31:0] INF32  = 32'h7F80_0000;
   localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
   localparam logic [7:0]  U8_BIAS = 8'd127;
   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SAMPLE_FORMAT = 2'd0;

   typedef struct packed {
      logic [63:0] raw_sample;
      logic        last_in_block;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] sample_bits;
   } rsp_payload_type;

   // Float32 bits of v * 2^-scale, |v| <= 2^31. Priority encode then round.
   function automatic logic [31:0] int_to_float(input logic signed [32:0] v,
                                                input logic [7:0] scale);
      logic [31:0] mag;
      logic [4:0]  p;
      logic [31:0] norm;
      logic [23:0] mant;
      logic        guard;
      logic        sticky;
      logic [24:0] rounded;
      logic [7:0]  expo;
      logic        sgn;
      sgn = v[32];
      mag = sgn ? 32'(-v) : v[31:0];
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            p = 5'(i);
         end
      end
      norm = mag << (5'd31 - p);
      mant = norm[31:8];
      guard = norm[7];
      sticky = |norm[6:0];
      rounded = {1'b0, mant} + 25'(guard && (sticky || mant[0]));
      expo = 8'(p) - scale + 8'd127;
      if (rounded[24]) begin
         expo = expo + 8'd1;
         rounded = rounded >> 1;
      end
      if (v == '0) begin
         int_to_float = '0;
      end else begin
         int_to_float = {sgn, expo, rounded[22:0]};
      end
   endfunction

   function automatic logic [31:0] narrow_f64(input logic [63:0] x);
      logic        sgn;
      logic [10:0] ex;
      logic [51:0] frac;
      logic [52:0] m;
      logic signed [12:0] fe;
      logic [11:0] sh;
      logic [52:0] q;
      logic [52:0] rem_mask;
      logic        guard;
      logic        sticky;
      logic [24:0] rounded;
      logic [31:0] r;
      sgn = x[63];
      ex = x[62:52];
      frac = x[51:0];
      m = {1'b1, frac};
      fe = 13'(ex) - 13'sd896;
      r = '0;
      if (ex == 11'h7FF) begin
         r = (frac == '0) ? (INF32 | {sgn, 31'd0})
                          : ({sgn, 31'd0} | QNAN32 | {9'd0, frac[51:29]});
      end else if (ex == '0) begin
         r = {sgn, 31'd0};
      end else if (fe >= 13'sd255) begin
         r = {sgn, 31'd0} | INF32;
      end else if (fe >= 13'sd1) begin
         rounded = {1'b0, m[52:29]} + 25'(m[28] && ((|m[27:0]) || m[29]));
         if (rounded[24]) begin
            if (fe >= 13'sd254) begin
               r = {sgn, 31'd0} | INF32;
            end else begin
               r = {sgn, 8'(fe + 13'sd1), 23'd0};
            end
         end else begin
            r = {sgn, 8'(fe), rounded[22:0]};
         end
      end else begin
         sh = 12'(13'sd30 - fe);
         if (sh >= 12'd54) begin
            r = {sgn, 31'd0};
         end else begin
            q = m >> sh;
            guard = m[6'(sh - 12'd1)];
            rem_mask = (53'd1 << (sh - 12'd1)) - 53'd1;
            sticky = |(m & rem_mask);
            rounded = q[24:0] + 25'(guard && (sticky || q[0]));
            r = {sgn, 7'd0, rounded[23:0]};
         end
      end
      narrow_f64 = r;
   endfunction

endpackage

// ===== rtl/core/sfc_stream_if.sv =====
interface sfc_stream_if #(
   parameter int unsigned WIDTH = 32
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sample_to_float_converter_unit.sv =====
// Converts one raw PCM sample per transfer into IEEE single-precision bits.
// The format register (offset 0) selects u8, s16, s32, f32, f64, s8 delta or
// s16 delta; delta formats keep a 16-bit running sum that clears after a
// transfer marked last_in_block. One sample is accepted every cycle while the
// result side is not stalled; an accepted sample passes through the input
// register, then the result register, with the single conversion stage
// between them. Write the format only while no sample is in flight.
module sample_to_float_converter_unit (
   input  logic                               clock,
   input  logic                               reset,
   sfc_stream_if.sink                         req,
   sfc_stream_if.source                       rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sfc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import sfc_pkg::*;

   logic [2:0]  format_ff;
   logic [15:0] acc_ff, acc_in;
   logic        s1_valid_ff;
   logic [63:0] s1_raw_ff;
   logic        s1_last_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_bits_ff, rsp_bits_in;
   logic        s1_advance;
   logic        s1_ready;
   logic [15:0] sum8, sum16;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_SAMPLE_FORMAT) ? {29'd0, format_ff} : 32'd0;

   assign s1_advance = !rsp_valid_ff || rsp.ready;
   assign s1_ready = !s1_valid_ff || s1_advance;
   assign req.ready = s1_ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == CSR_SAMPLE_FORMAT) begin
         format_ff <= csr_pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req.valid;
         end
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_valid_ff && s1_advance) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && s1_ready) begin
         s1_raw_ff <= req.payload[64:1];
         s1_last_ff <= req.payload[0];
      end
      if (s1_valid_ff && s1_advance) begin
         rsp_bits_ff <= rsp_bits_in;
      end
   end

   assign sum8 = {8'd0, acc_ff[7:0] + s1_raw_ff[7:0]};
   assign sum16 = acc_ff + s1_raw_ff[15:0];

   always_comb begin
      acc_in = acc_ff;
      rsp_bits_in = '0;
      case (format_ff)
         FMT_U8: rsp_bits_in = int_to_float(33'(s1_raw_ff[7:0]) - 33'(U8_BIAS), 8'd7);
         FMT_S16: rsp_bits_in = int_to_float(33'($signed(s1_raw_ff[15:0])), 8'd15);
         FMT_S32: rsp_bits_in = int_to_float(33'($signed(s1_raw_ff[31:0])), 8'd31);
         FMT_F32: rsp_bits_in = s1_raw_ff[31:0];
         FMT_F64: rsp_bits_in = narrow_f64(s1_raw_ff);
         FMT_S8_DELTA: begin
            acc_in = sum8;
            rsp_bits_in = int_to_float(33'($signed(sum8[7:0])), 8'd7);
         end
         FMT_S16_DELTA: begin
            acc_in = sum16;
            rsp_bits_in = int_to_float(33'($signed(sum16)), 8'd15);
         end
         default: rsp_bits_in = '0;
      endcase
      if (s1_last_ff) begin
         acc_in = '0;
      end
   end
endmodule

// ===== rtl/core/sfc_checker.sv =====
module sfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [31:0] rsp_payload
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid || $past(rsp_valid && !rsp_ready))
      else $error("accepted sample did not produce a result");
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind sample_to_float_converter_unit sfc_checker u_sfc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

// ===== sim/sfc_conv_checker.sv =====
`timescale 1ns / 100ps

module sfc_conv_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [64:0] req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [sfc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          error_count,
   output int          pending_count
);
   import sfc_pkg::*;

   logic [2:0]  cur_format;
   logic [15:0] running_sum;
   logic [31:0] expected_bits[$];

   // Shift right with round to nearest even; sh is 1..63.
   function automatic logic [63:0] shift_rne(input logic [63:0] m, input int sh);
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) begin
         q = q + 64'd1;
      end
      return q;
   endfunction

   function automatic logic [31:0] scaled_single(input longint v, input int scale);
      logic        sgn;
      logic [63:0] mag;
      logic [63:0] mant;
      int          p;
      if (v == 0) begin
         return 32'd0;
      end
      sgn = (v < 0);
      mag = sgn ? 64'(-v) : 64'(v);
      p = 0;
      while (p < 63 && (mag >> (p + 1)) != 0) begin
         p++;
      end
      if (p <= 23) begin
         mant = mag << (23 - p);
      end else begin
         mant = shift_rne(mag, p - 23);
         if (mant == (64'd1 << 24)) begin
            mant = mant >> 1;
            p++;
         end
      end
      return {sgn, 8'(p - scale + 127), mant[22:0]};
   endfunction

   function automatic logic [31:0] double_to_single(input logic [63:0] x);
      logic [31:0] sgn;
      int          ex;
      int          fe;
      logic [63:0] m;
      logic [63:0] mant;
      sgn = {x[63], 31'd0};
      ex = int'(x[62:52]);
      if (ex == 2047) begin
         if (x[51:0] == '0) begin
            return sgn | INF32;
         end
         return sgn | QNAN32 | {9'd0, x[51:29]};
      end
      if (ex == 0) begin
         return sgn;
      end
      m = {11'd1, x[51:0]};
      fe = ex - 1023 + 127;
      if (fe >= 255) begin
         return sgn | INF32;
      end
      if (fe >= 1) begin
         mant = shift_rne(m, 29);
         if (mant == (64'd1 << 24)) begin
            mant = mant >> 1;
            fe++;
            if (fe >= 255) begin
               return sgn | INF32;
            end
         end
         return sgn | {1'b0, 8'(fe), mant[22:0]};
      end
      if (30 - fe >= 64) begin
         return sgn;
      end
      // A carry into bit 23 lands exactly on the smallest normal.
      mant = shift_rne(m, 30 - fe);
      return sgn | mant[31:0];
   endfunction

   always @(posedge clock) begin
      logic [63:0] raw;
      logic [31:0] want;
      if (reset) begin
         cur_format <= FMT_U8;
         running_sum <= '0;
         expected_bits.delete();
         error_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_SAMPLE_FORMAT) begin
            cur_format <= csr_pwdata[2:0];
         end
         if (req_valid && req_ready) begin
            raw = req_payload[64:1];
            want = '0;
            case (cur_format)
               FMT_U8: want = scaled_single(longint'(raw[7:0]) - 127, 7);
               FMT_S16: want = scaled_single(longint'($signed(raw[15:0])), 15);
               FMT_S32: want = scaled_single(longint'($signed(raw[31:0])), 31);
               FMT_F32: want = raw[31:0];
               FMT_F64: want = double_to_single(raw);
               FMT_S8_DELTA: begin
                  running_sum[15:8] = '0;
                  running_sum[7:0] = running_sum[7:0] + raw[7:0];
                  want = scaled_single(longint'($signed(running_sum[7:0])), 7);
               end
               FMT_S16_DELTA: begin
                  running_sum = running_sum + raw[15:0];
                  want = scaled_single(longint'($signed(running_sum)), 15);
               end
               default: want = '0;
            endcase
            if (req_payload[0]) begin
               running_sum = '0;
            end
            expected_bits.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bits.size() == 0) begin
               $error("sample_bits: unexpected transfer, actual %h", rsp_payload);
               error_count <= error_count + 1;
            end else begin
               want = expected_bits.pop_front();
               if (want !== rsp_payload) begin
                  $error("sample_bits: expected %h, actual %h", want, rsp_payload);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = expected_bits.size();
endmodule

// ===== sim/sample_to_float_converter_unit_tb.sv =====
`timescale 1ns / 100ps

module sample_to_float_converter_unit_tb;
   import sfc_pkg::*;

   localparam logic [2:0] FMT_UNUSED_CODE = 3'd7;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int   error_count;
   int   pending_count;
   int   gap_pct;
   int   stall_pct;
   bit   hold_rsp;

   sfc_stream_if #(.WIDTH(65)) req_if ();
   sfc_stream_if #(.WIDTH(32)) rsp_if ();

   sample_to_float_converter_unit u_top (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   sfc_conv_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_payload(req_if.payload),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_payload(rsp_if.payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("sample_to_float_converter_unit: mismatch");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_sample(input logic [63:0] raw, input logic last);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= {raw, last};
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_format(input logic [2:0] fmt);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_SAMPLE_FORMAT;
      csr_pwdata <= 32'(fmt);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_sample(input logic [2:0] fmt);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if (fmt == FMT_F64 && $urandom_range(3) != 0) begin
         // Keep most doubles near the single-precision range and its edges.
         raw[62:52] = 11'($urandom_range(840, 1160));
         if ($urandom_range(3) == 0) begin
            raw[28:0] = $urandom_range(1) ? 29'h1000_0000 : 29'h0;
         end
      end
      return raw;
   endfunction

   initial begin
      logic [2:0] fmt;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gap_pct = 0;
      stall_pct = 0;
      hold_rsp = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset format is u8: bias extremes with junk in the upper bits.
      send_sample(64'hFFFF_FFFF_FFFF_FF00, 1'b0);
      send_sample(64'h0000_0000_0000_007F, 1'b0);
      send_sample(64'hA5A5_0000_0000_0080, 1'b1);
      send_sample(64'h0000_0000_0000_00FF, 1'b0);
      set_format(FMT_S16);
      send_sample(64'h0000_0000_0000_8000, 1'b0);
      send_sample(64'hFFFF_FFFF_FFFF_7FFF, 1'b0);
      set_format(FMT_S32);
      send_sample(64'h0000_0000_8000_0000, 1'b0);
      send_sample(64'h0000_0000_7FFF_FFFF, 1'b0);
      send_sample(64'h0000_0000_0100_0003, 1'b0);
      set_format(FMT_F32);
      send_sample(64'h1234_5678_7FC0_0001, 1'b0);
      set_format(FMT_F64);
      send_sample(64'h7FF0_0000_0000_0000, 1'b0);
      send_sample(64'hFFF8_0000_2000_0001, 1'b0);
      send_sample(64'h000F_FFFF_FFFF_FFFF, 1'b0);
      send_sample(64'h47EF_FFFF_F000_0000, 1'b0);
      send_sample(64'h380F_FFFF_F000_0000, 1'b0);
      send_sample(64'hB690_0000_0000_0001, 1'b0);
      send_sample(64'h3FF0_0000_1000_0000, 1'b0);
      set_format(FMT_S8_DELTA);
      send_sample(64'h0000_0000_0000_007F, 1'b0);
      send_sample(64'h0000_0000_0000_0001, 1'b0);
      send_sample(64'h0000_0000_0000_0080, 1'b1);
      set_format(FMT_S16_DELTA);
      send_sample(64'h0000_0000_0000_7FFF, 1'b0);
      send_sample(64'h0000_0000_0000_0001, 1'b0);
      // Delta sum carries over into a new format without a last mark.
      set_format(FMT_S8_DELTA);
      send_sample(64'h0000_0000_0000_0003, 1'b0);
      set_format(FMT_UNUSED_CODE);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         gap_pct = (ph == 1) ? 48 : (ph == 3) ? 35 : 0;
         stall_pct = (ph == 2) ? 48 : (ph == 3) ? 35 : 0;
         for (int j = 0; j < 6; j++) begin
            fmt = 3'((ph * 6 + j) % 8);
            set_format(fmt);
            if (ph == 0 && j == 2) begin
               hold_rsp = 1'b1;
            end
            for (int k = 0; k < 25; k++) begin
               if (ph == 1 && j == 3 && k == 12) begin
                  drain();
               end
               send_sample(random_sample(fmt), $urandom_range(7) == 0);
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("sample_to_float_converter_unit: match");
      end else begin
         $display("sample_to_float_converter_unit: mismatch");
      end
      $finish;
   end
endmodule
